// ===== design/smmf_pkg.sv =====
`default_nettype none
package smmf_pkg;

  localparam int MAX_LINE_WIDTH_DEF = 2048;
  localparam int RADIUS_LIMIT_DEF   = 8;
  localparam int DIM_CAP            = 2048;

  localparam int PIX_W    = 8;
  localparam int DIM_W    = 12;
  localparam int POS_W    = 11;
  localparam int RAD_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [DIM_W-1:0] dim_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [RAD_W-1:0] rad_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_RADIUS_X     = 3'd2,
    CFG_RADIUS_Y     = 3'd3,
    CFG_FILTER_MODE  = 3'd4
  } cfg_idx_t;

  localparam dim_t RST_FRAME_WIDTH  = 12'd2048;
  localparam dim_t RST_FRAME_HEIGHT = 12'd2048;
  localparam rad_t RST_RADIUS       = 4'd1;
  localparam logic MODE_MAX         = 1'b0;
  localparam logic MODE_MIN         = 1'b1;
  localparam pix_t PIX_ZERO         = 8'd0;
  localparam pix_t PIX_FULL         = 8'd255;

  typedef struct packed {
    pix_t filtered;
    pos_t out_x;
    pos_t out_y;
    logic frame_done;
    pix_t frame_extreme;
  } res_t;

  function automatic pix_t pick(pix_t a, pix_t b, logic mode);
    if (mode == MODE_MIN) begin
      return (a < b) ? a : b;
    end
    return (a > b) ? a : b;
  endfunction

  function automatic pix_t ident(logic mode);
    return (mode == MODE_MIN) ? PIX_FULL : PIX_ZERO;
  endfunction

endpackage
`default_nettype wire

// ===== design/smmf_if.sv =====
`default_nettype none
interface smmf_pix_if;
  import smmf_pkg::*;
  logic valid;
  logic ready;
  pix_t pixel;
  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface smmf_res_if;
  import smmf_pkg::*;
  logic valid;
  logic ready;
  pix_t filtered;
  pos_t out_x;
  pos_t out_y;
  logic frame_done;
  pix_t frame_extreme;
  modport source (output valid, output filtered, output out_x, output out_y,
                  output frame_done, output frame_extreme, input ready);
  modport sink (input valid, input filtered, input out_x, input out_y,
                input frame_done, input frame_extreme, output ready);
endinterface
`default_nettype wire

// ===== design/smmf_ram.sv =====
`default_nettype none
module smmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/separable_max_min_window_filter.sv =====
`default_nettype none
// Separable max (dilation) or min (erosion) filter over 8-bit pixels in raster order.
// One pixel is accepted per clock unless the output queue is full; each result is
// registered in s1 and then queued. Each pixel reads one word of the column memory,
// which holds the last 2*RADIUS_LIMIT horizontal results of every column, and rewrites
// it once its horizontal window is full. The memory needs no clearing after reset.
// Border positions give no result; the frame-wide extreme comes with the frame's last
// result. Configuration must be written only while idle; the block does not enforce it.
module separable_max_min_window_filter #(
  parameter int MAX_LINE_WIDTH = smmf_pkg::MAX_LINE_WIDTH_DEF,
  parameter int RADIUS_LIMIT   = smmf_pkg::RADIUS_LIMIT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  smmf_pix_if.sink                              in_chan,
  smmf_res_if.source                            out_chan,
  input  wire logic                             cfg_we,
  input  wire logic [smmf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [smmf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import smmf_pkg::*;

  localparam int LINES = 2 * RADIUS_LIMIT;
  localparam int TAPS  = LINES + 1;
  localparam int LV    = $clog2(TAPS);
  localparam int NP    = 1 << LV;
  localparam int AW    = $clog2(MAX_LINE_WIDTH);
  localparam int MW    = PIX_W * LINES;
  localparam int WCAP  = (MAX_LINE_WIDTH < DIM_CAP) ? MAX_LINE_WIDTH : DIM_CAP;
  localparam int RCAP  = (RADIUS_LIMIT < 15) ? RADIUS_LIMIT : 15;
  localparam int QD    = 3;

  dim_t fw_r, fh_r;
  rad_t rx_r, ry_r;
  logic mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r   <= RST_FRAME_WIDTH;
      fh_r   <= RST_FRAME_HEIGHT;
      rx_r   <= RST_RADIUS;
      ry_r   <= RST_RADIUS;
      mode_r <= MODE_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  fw_r   <= cfg_wdata[DIM_W-1:0];
        CFG_FRAME_HEIGHT: fh_r   <= cfg_wdata[DIM_W-1:0];
        CFG_RADIUS_X:     rx_r   <= cfg_wdata[RAD_W-1:0];
        CFG_RADIUS_Y:     ry_r   <= cfg_wdata[RAD_W-1:0];
        CFG_FILTER_MODE:  mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  dim_t w, h;
  rad_t rx, ry;
  logic [RAD_W:0] two_rx, two_ry;

  always_comb begin
    if (fw_r == '0) w = dim_t'(1);
    else if (fw_r > dim_t'(WCAP)) w = dim_t'(WCAP);
    else w = fw_r;
    if (fh_r == '0) h = dim_t'(1);
    else if (fh_r > dim_t'(DIM_CAP)) h = dim_t'(DIM_CAP);
    else h = fh_r;
    if (rx_r == '0) rx = rad_t'(1);
    else if (rx_r > rad_t'(RCAP)) rx = rad_t'(RCAP);
    else rx = rx_r;
    if (ry_r == '0) ry = rad_t'(1);
    else if (ry_r > rad_t'(RCAP)) ry = rad_t'(RCAP);
    else ry = ry_r;
    two_rx = {rx, 1'b0};
    two_ry = {ry, 1'b0};
  end

  pos_t col_r, row_r, col_nxt, row_nxt;
  pix_t ext_r, ext_nxt;
  pix_t taps_r [LINES];
  logic accept;
  pix_t p;
  pos_t c0, r0, cx, oy;
  dim_t r1, cn, rr;
  logic hvalid, vvalid, done;
  pix_t hv;
  pix_t harr [NP];

  assign accept = in_chan.valid & in_chan.ready;
  assign p      = in_chan.pixel;

  always_comb begin
    if ({1'b0, col_r} >= w) begin
      c0 = '0;
      r1 = {1'b0, row_r} + dim_t'(1);
    end else begin
      c0 = col_r;
      r1 = {1'b0, row_r};
    end
    r0 = (r1 >= h) ? '0 : r1[POS_W-1:0];
    if (c0 == '0 && r0 == '0) ext_nxt = p;
    else ext_nxt = pick(ext_r, p, mode_r);
    cn = {1'b0, c0} + dim_t'(1);
    rr = {1'b0, r0} + dim_t'(1);
    if (cn >= w) begin
      col_nxt = '0;
      row_nxt = (rr >= h) ? '0 : rr[POS_W-1:0];
    end else begin
      col_nxt = cn[POS_W-1:0];
      row_nxt = r0;
    end
    hvalid = c0 >= pos_t'(two_rx);
    vvalid = hvalid && (r0 >= pos_t'(two_ry));
    cx     = c0 - pos_t'(rx);
    oy     = r0 - pos_t'(ry);
    done   = ({1'b0, c0} == w - dim_t'(1)) && ({1'b0, r0} == h - dim_t'(1));
  end

  always_comb begin
    for (int k = 0; k < NP; k++) begin
      if (k == 0) harr[k] = p;
      else if (k <= LINES && k <= int'(two_rx)) harr[k] = taps_r[k-1];
      else harr[k] = ident(mode_r);
    end
    for (int lv = 0; lv < LV; lv++) begin
      for (int i = 0; i < (NP >> (lv + 1)); i++) begin
        harr[i] = pick(harr[2*i], harr[2*i+1], mode_r);
      end
    end
    hv = harr[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      ext_r <= PIX_ZERO;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      ext_r <= ext_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      taps_r[0] <= p;
      for (int k = 1; k < LINES; k++) begin
        taps_r[k] <= taps_r[k-1];
      end
    end
  end

  logic s1_wr_r, s1_out_r;
  pix_t s1_hv_r, s1_ext_r;
  pos_t s1_cx_r, s1_y_r;
  logic s1_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_wr_r  <= 1'b0;
      s1_out_r <= 1'b0;
    end else begin
      s1_wr_r  <= accept & hvalid;
      s1_out_r <= accept & vvalid;
    end
  end

  always_ff @(posedge clk) begin
    s1_hv_r   <= hv;
    s1_cx_r   <= cx;
    s1_y_r    <= oy;
    s1_done_r <= done;
    s1_ext_r  <= ext_nxt;
  end

  logic [MW-1:0] rd_data, wr_data;

  assign wr_data = {rd_data[MW-PIX_W-1:0], s1_hv_r};

  smmf_ram #(
    .WIDTH (MW),
    .DEPTH (MAX_LINE_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (s1_wr_r),
    .waddr (AW'(s1_cx_r)),
    .wdata (wr_data),
    .raddr (AW'(cx)),
    .rdata (rd_data)
  );

  pix_t varr [NP];
  res_t s1_res;

  always_comb begin
    for (int k = 0; k < NP; k++) begin
      if (k == 0) varr[k] = s1_hv_r;
      else if (k <= LINES && k <= int'(two_ry)) varr[k] = rd_data[PIX_W*(k-1) +: PIX_W];
      else varr[k] = ident(mode_r);
    end
    for (int lv = 0; lv < LV; lv++) begin
      for (int i = 0; i < (NP >> (lv + 1)); i++) begin
        varr[i] = pick(varr[2*i], varr[2*i+1], mode_r);
      end
    end
    s1_res.filtered      = varr[0];
    s1_res.out_x         = s1_cx_r;
    s1_res.out_y         = s1_y_r;
    s1_res.frame_done    = s1_done_r;
    s1_res.frame_extreme = s1_done_r ? s1_ext_r : PIX_ZERO;
  end

  res_t q_r [QD];
  logic [1:0] wp_r, rp_r, cnt_r;
  logic pop;

  assign pop = out_chan.valid & out_chan.ready;
  assign in_chan.ready = ({1'b0, cnt_r} + {2'b00, s1_out_r}) < 3'd3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (s1_out_r) wp_r <= (wp_r == 2'd2) ? 2'd0 : wp_r + 2'd1;
      if (pop) rp_r <= (rp_r == 2'd2) ? 2'd0 : rp_r + 2'd1;
      cnt_r <= cnt_r + {1'b0, s1_out_r} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (s1_out_r) begin
      q_r[wp_r] <= s1_res;
    end
  end

  assign out_chan.valid         = cnt_r != '0;
  assign out_chan.filtered      = q_r[rp_r].filtered;
  assign out_chan.out_x         = q_r[rp_r].out_x;
  assign out_chan.out_y         = q_r[rp_r].out_y;
  assign out_chan.frame_done    = q_r[rp_r].frame_done;
  assign out_chan.frame_extreme = q_r[rp_r].frame_extreme;

endmodule
`default_nettype wire
